>>> design/pfte_pkg.sv
package pfte_pkg;

  // Geometry of the panel image.
  localparam int WIDTH  = 128;
  localparam int HEIGHT = 64;
  localparam int PAGES  = 8;

  // Each memory row holds eight adjacent column bytes of one page.
  localparam int WORDS  = (WIDTH + 7) / 8;
  localparam int ROWS   = PAGES * WORDS;
  localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int NWORDS = (WORDS > 16) ? 16 : WORDS;

  localparam int CELL_COLS = 6;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] DIRTY_RESET   = 8'hFF;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_CELL    = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_REFRESH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    WHAT_CMD  = 2'd0,
    WHAT_DATA = 2'd1,
    WHAT_NONE = 2'd2
  } what_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_CLR_RD,
    ST_CLR_CMP,
    ST_REF_CMD,
    ST_REF_DATA
  } state_t;

  // One masked read-modify-write of a memory row.
  typedef struct packed {
    logic [AW-1:0] addr;
    logic [2:0]    page;
    logic [63:0]   mask;
    logic [63:0]   value;
  } rmw_op_t;

  // Packs five font columns with column zero in the low byte.
  function automatic logic [39:0] cols5(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [7:0] c3,
                                        input logic [7:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  // 5x7 glyph of a character code; codes without a glyph are blank.
  function automatic logic [39:0] font_glyph(input logic [7:0] code);
    logic [39:0] g;
    case (code)
      8'h41, 8'h61: g = cols5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      8'h42, 8'h62: g = cols5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h43, 8'h63: g = cols5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      8'h44, 8'h64: g = cols5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      8'h45, 8'h65: g = cols5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      8'h46, 8'h66: g = cols5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      8'h47, 8'h67: g = cols5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
      8'h48, 8'h68: g = cols5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      8'h49, 8'h69: g = cols5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      8'h4A, 8'h6A: g = cols5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
      8'h4B, 8'h6B: g = cols5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      8'h4C, 8'h6C: g = cols5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      8'h4D, 8'h6D: g = cols5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      8'h4E, 8'h6E: g = cols5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      8'h4F, 8'h6F: g = cols5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      8'h50, 8'h70: g = cols5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      8'h51, 8'h71: g = cols5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      8'h52, 8'h72: g = cols5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      8'h53, 8'h73: g = cols5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      8'h54, 8'h74: g = cols5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      8'h55, 8'h75: g = cols5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      8'h56, 8'h76: g = cols5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      8'h57, 8'h77: g = cols5(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
      8'h58, 8'h78: g = cols5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      8'h59, 8'h79: g = cols5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      8'h5A, 8'h7A: g = cols5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      8'h30: g = cols5(8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E);
      8'h31: g = cols5(8'h00, 8'h21, 8'h7F, 8'h01, 8'h00);
      8'h32: g = cols5(8'h23, 8'h45, 8'h49, 8'h51, 8'h21);
      8'h33: g = cols5(8'h42, 8'h41, 8'h51, 8'h69, 8'h46);
      8'h34: g = cols5(8'h0C, 8'h14, 8'h24, 8'h7F, 8'h04);
      8'h35: g = cols5(8'h72, 8'h51, 8'h51, 8'h51, 8'h4E);
      8'h36: g = cols5(8'h1E, 8'h29, 8'h49, 8'h49, 8'h06);
      8'h37: g = cols5(8'h40, 8'h47, 8'h48, 8'h50, 8'h60);
      8'h38: g = cols5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h39: g = cols5(8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C);
      8'h3A: g = cols5(8'h00, 8'h14, 8'h00, 8'h14, 8'h00);
      8'h2E: g = cols5(8'h00, 8'h00, 8'h40, 8'h00, 8'h00);
      8'h2D: g = cols5(8'h00, 8'h08, 8'h08, 8'h08, 8'h00);
      8'h2F: g = cols5(8'h40, 8'h20, 8'h10, 8'h08, 8'h04);
      8'h3E: g = cols5(8'h08, 8'h14, 8'h22, 8'h41, 8'h41);
      8'h23: g = cols5(8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14);
      8'h25: g = cols5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

>>> design/pfte_ram.sv
module pfte_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pfte_op_gen.sv
module pfte_op_gen
  import pfte_pkg::*;
(
  input  logic [1:0] kind,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic       pixel_on,
  input  logic [7:0] char_code,
  input  logic       inverted,
  input  logic [1:0] op_idx,
  output rmw_op_t    op
);

  // Builds the masked update of one memory row. A cell covers at most two
  // rows across and two pages down; op_idx picks which of the four.
  always_comb begin
    logic [5:0]  pg;
    logic [5:0]  w;
    logic [11:0] full;
    logic [7:0]  hmask;
    logic        origin_ok;
    logic        in_page;
    logic        addr_ok;
    logic [39:0] glyph;
    logic [9:0]  col;
    logic [9:0]  rel;
    logic        inr;
    logic [7:0]  gb;
    logic [15:0] vwide;
    logic [15:0] mwide;
    logic [63:0] m;
    logic [63:0] v;

    glyph = font_glyph(char_code);
    if (kind == KIND_PIXEL) begin
      pg = {1'b0, y[7:3]};
      w  = {1'b0, x[7:3]};
    end else begin
      pg = {1'b0, y[7:3]} + 6'(op_idx[1]);
      w  = {1'b0, x[7:3]} + 6'(op_idx[0]);
    end
    origin_ok = ({2'b0, x} < 10'(WIDTH)) && ({2'b0, y} < 10'(HEIGHT));
    in_page   = pg < 6'(PAGES);
    addr_ok   = in_page && ({1'b0, w} < 7'(WORDS));
    for (int r = 0; r < 8; r++) begin
      hmask[r] = (10'({pg, 3'b000}) + 10'(r)) < 10'(HEIGHT);
    end

    m     = '0;
    v     = '0;
    col   = '0;
    rel   = '0;
    inr   = 1'b0;
    gb    = '0;
    vwide = '0;
    mwide = '0;
    if (kind == KIND_PIXEL) begin
      m = 64'(1) << {x[2:0], y[2:0]};
      v = pixel_on ? m : '0;
    end else begin
      for (int j = 0; j < 8; j++) begin
        col = 10'({w, 3'b000}) + 10'(j);
        rel = col - {2'b0, x};
        inr = (col >= {2'b0, x}) && (rel < 10'(CELL_COLS)) && (col < 10'(WIDTH));
        gb  = (rel < 10'(5)) ? glyph[{rel[2:0], 3'b000} +: 8] : 8'h00;
        if (inverted) begin
          gb = ~gb;
        end
        vwide = {8'h00, gb} << y[2:0];
        mwide = 16'h00FF << y[2:0];
        m[j*8 +: 8] = inr ? ((op_idx[1] ? mwide[15:8] : mwide[7:0]) & hmask) : 8'h00;
        v[j*8 +: 8] = op_idx[1] ? vwide[15:8] : vwide[7:0];
      end
    end

    if (!(origin_ok && addr_ok)) begin
      m = '0;
    end
    full     = 12'(pg) * 12'(WORDS) + 12'(w);
    op.addr  = addr_ok ? full[AW-1:0] : '0;
    op.page  = pg[2:0];
    op.mask  = m;
    op.value = v & m;
  end

endmodule

>>> design/page_framebuffer_text_engine_core.sv
// Page-organized 128x64 monochrome framebuffer with a 5x7 text cell engine.
//
// Items come in on start with kind, x, y, pixel_on, char_code and inverted;
// one is taken at a clock edge where start is high and busy is low. Pixel
// writes, character cells and clears update the image and return nothing.
// A refresh returns a page address command word and then one data word of
// eight column bytes per cycle for the lowest dirty page, or a single
// "nothing dirty" word. Each result word sits on what, word and last for
// exactly one cycle with strobe high; the receiver cannot stall it.
//
// Work per item: a pixel write is one masked read-modify-write of the frame
// memory, a character cell four, each a read state and a write state. A
// clear sweeps every frame row against its shadow row, a read state and a
// compare state per row. A refresh passes a command state, then a data state
// per word of the page (only the command state if none is dirty); the first
// word is registered from the command state, the rest follow one per cycle,
// the last as busy drops, bounded by the single frame memory read port.
//
// Reset is synchronous. It marks every page dirty and clears the row valid
// bits, so both memories read as all zeros until rows are written again.
module page_framebuffer_text_engine_core
  import pfte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  x,
  input  logic [7:0]  y,
  input  logic        pixel_on,
  input  logic [7:0]  char_code,
  input  logic        inverted,
  output logic        strobe,
  output logic [1:0]  what,
  output logic [63:0] word,
  output logic        last
);

  state_t state, state_next;

  // Latched item.
  kind_t      kind_r;
  logic [7:0] x_r, y_r, code_r;
  logic       on_r, inv_r;

  logic [1:0]      op_idx;
  logic [7:0]      dirty;
  logic [ROWS-1:0] frame_valid, shadow_valid;
  logic            fv_q, sv_q;
  logic [2:0]      clr_page;
  logic [KW-1:0]   clr_word;
  logic            act;
  logic [2:0]      ref_page;
  logic            ref_found;
  logic [KW-1:0]   ref_k;

  logic [2:0] low_page;
  logic       low_found;

  what_t      what_r;
  logic [63:0] word_r;
  logic        last_r;

  // Memory ports.
  logic          fr_we, sh_we;
  logic [AW-1:0] fr_raddr, fr_waddr, sh_raddr, sh_waddr;
  logic [63:0]   fr_wdata, fr_rdata, sh_rdata;

  rmw_op_t     op;
  logic [63:0] fr_old, sh_old, rmw_new;
  logic        rmw_change;
  logic [11:0] clr_full, ref_full_rd, ref_full_wr;
  logic [AW-1:0] clr_addr;
  logic        clr_row_last, clr_page_last, act_now;

  pfte_op_gen u_op_gen (
    .kind      (kind_r),
    .x         (x_r),
    .y         (y_r),
    .pixel_on  (on_r),
    .char_code (code_r),
    .inverted  (inv_r),
    .op_idx    (op_idx),
    .op        (op)
  );

  // Frame image, eight column bytes per row.
  pfte_ram #(.W(64), .D(ROWS)) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  // Copy of what the panel currently shows.
  pfte_ram #(.W(64), .D(ROWS)) u_shadow_ram (
    .clk   (clk),
    .we    (sh_we),
    .waddr (sh_waddr),
    .wdata (fr_old),
    .raddr (sh_raddr),
    .rdata (sh_rdata)
  );

  // A row that was never written since reset, or was cleared, reads as zero.
  assign fr_old     = fv_q ? fr_rdata : '0;
  assign sh_old     = sv_q ? sh_rdata : '0;
  assign rmw_new    = (fr_old & ~op.mask) | op.value;
  assign rmw_change = rmw_new != fr_old;
  assign fr_wdata   = rmw_new;
  assign fr_waddr   = op.addr;

  assign clr_full      = 12'(clr_page) * 12'(WORDS) + 12'(clr_word);
  assign clr_addr      = clr_full[AW-1:0];
  assign clr_page_last = clr_word == KW'(WORDS - 1);
  assign clr_row_last  = clr_page_last && (clr_page == 3'(PAGES - 1));
  assign act_now       = act || (fr_old != sh_old) || (fr_old != '0);

  assign ref_full_rd = 12'(ref_page) * 12'(WORDS) + 12'(ref_k) + 12'd1;
  assign ref_full_wr = 12'(ref_page) * 12'(WORDS) + 12'(ref_k);
  assign sh_waddr    = ref_full_wr[AW-1:0];

  // Lowest dirty page below PAGES.
  always_comb begin
    low_page  = '0;
    low_found = 1'b0;
    for (int p = PAGES - 1; p >= 0; p--) begin
      if (dirty[p]) begin
        low_page  = 3'(p);
        low_found = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    fr_raddr   = op.addr;
    sh_raddr   = clr_addr;
    fr_we      = 1'b0;
    sh_we      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (kind_t'(kind))
            KIND_PIXEL, KIND_CELL: state_next = ST_RMW_RD;
            KIND_CLEAR:            state_next = ST_CLR_RD;
            KIND_REFRESH:          state_next = ST_REF_CMD;
          endcase
        end
      end
      ST_RMW_RD: begin
        state_next = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        fr_we = rmw_change;
        if (kind_r == KIND_CELL && op_idx != 2'd3) begin
          state_next = ST_RMW_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CLR_RD: begin
        fr_raddr   = clr_addr;
        state_next = ST_CLR_CMP;
      end
      ST_CLR_CMP: begin
        state_next = clr_row_last ? ST_IDLE : ST_CLR_RD;
      end
      ST_REF_CMD: begin
        fr_raddr   = ref_full_wr[AW-1:0];
        state_next = ref_found ? ST_REF_DATA : ST_IDLE;
      end
      ST_REF_DATA: begin
        fr_raddr   = ref_full_rd[AW-1:0];
        sh_we      = 1'b1;
        state_next = (ref_k == KW'(WORDS - 1)) ? ST_IDLE : ST_REF_DATA;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      dirty        <= DIRTY_RESET;
      frame_valid  <= '0;
      shadow_valid <= '0;
      strobe       <= 1'b0;
      op_idx       <= '0;
      clr_page     <= '0;
      clr_word     <= '0;
      act          <= 1'b0;
      ref_k        <= '0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_REF_CMD) ||
                (state == ST_REF_DATA && {1'b0, ref_k} < (KW+1)'(NWORDS));
      unique case (state)
        ST_IDLE: begin
          op_idx   <= '0;
          clr_page <= '0;
          clr_word <= '0;
          act      <= 1'b0;
        end
        ST_RMW_WR: begin
          op_idx <= op_idx + 2'd1;
          if (rmw_change) begin
            frame_valid[op.addr] <= 1'b1;
            dirty[op.page]       <= 1'b1;
          end
        end
        ST_CLR_CMP: begin
          if (clr_page_last) begin
            // A page that holds ink or differs from the panel is blanked.
            if (act_now) begin
              for (int i = 0; i < ROWS; i++) begin
                if (3'(i / WORDS) == clr_page) begin
                  frame_valid[i] <= 1'b0;
                end
              end
              dirty[clr_page] <= 1'b1;
            end
            act      <= 1'b0;
            clr_word <= '0;
            clr_page <= clr_page + 3'd1;
          end else begin
            act      <= act_now;
            clr_word <= clr_word + KW'(1);
          end
        end
        ST_REF_CMD: begin
          ref_k <= '0;
        end
        ST_REF_DATA: begin
          shadow_valid[sh_waddr] <= 1'b1;
          ref_k <= ref_k + KW'(1);
          if (ref_k == KW'(WORDS - 1)) begin
            dirty[ref_page] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fv_q <= (32'(fr_raddr) < ROWS) ? frame_valid[fr_raddr] : 1'b0;
    sv_q <= (32'(sh_raddr) < ROWS) ? shadow_valid[sh_raddr] : 1'b0;
    if (state == ST_IDLE && start) begin
      kind_r    <= kind_t'(kind);
      x_r       <= x;
      y_r       <= y;
      on_r      <= pixel_on;
      code_r    <= char_code;
      inv_r     <= inverted;
      ref_page  <= low_page;
      ref_found <= low_found;
    end
    if (state == ST_REF_CMD) begin
      what_r <= ref_found ? WHAT_CMD : WHAT_NONE;
      word_r <= ref_found ? {40'h0, CMD_COL_HI, CMD_COL_LO, CMD_PAGE_BASE | {5'b0, ref_page}}
                          : '0;
      last_r <= !ref_found;
    end else if (state == ST_REF_DATA) begin
      what_r <= WHAT_DATA;
      word_r <= fr_old;
      last_r <= ref_k == KW'(NWORDS - 1);
    end
  end

  assign busy = state != ST_IDLE;
  assign what = what_r;
  assign word = word_r;
  assign last = last_r;

  // Every result word belongs to an item that kept the block busy.
  a_strobe_in_item: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result word without an item in progress");

  // The closing word of a refresh is never directly followed by another word.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result word right after the final word of a refresh");

  // An accepted item always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

endmodule
